// File: sv/trsmm_pkg.sv
// shared types, constants and fixed point helpers for the model matrix unit
// no dependencies
package trsmm_pkg;

  // q30 angle constants, wide enough for the reduced angle arithmetic
  localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
  localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [35:0] Q30_QTR_PI  = 36'sd843314857;
  localparam logic signed [35:0] Q30_3QTR_PI = 36'sd2529944570;
  localparam logic signed [31:0] Q30_ONE     = 32'sd1073741824;
  localparam logic signed [31:0] Q16_ONE     = 32'sd65536;

  localparam int HSTEPS  = 5;
  localparam int SC_LAT  = 20;
  localparam int ROT_LAT = 3;
  localparam int XF_DLY  = SC_LAT + ROT_LAT;

  localparam logic [1:0] LAST_ROW = 2'd3;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] sz;
  } xf_t;

  // horner divisors, innermost first
  function automatic int sin_div(input int i);
    int d;
    case (i)
      0: d = 110;
      1: d = 72;
      2: d = 42;
      3: d = 20;
      default: d = 6;
    endcase
    return d;
  endfunction

  function automatic int cos_div(input int i);
    int d;
    case (i)
      0: d = 90;
      1: d = 56;
      2: d = 30;
      3: d = 12;
      default: d = 2;
    endcase
    return d;
  endfunction

  // q30 product, floor shift
  function automatic q_t mulq(input q_t a, input q_t b);
    logic signed [63:0] p;
    p = a * b;
    return p[61:30];
  endfunction

endpackage

// File: sv/trsmm_hstep.sv
// one horner step: t_next = 1 - floor(r2*t) / D, three register stages
// depends on trsmm_pkg
module trsmm_hstep #(
  parameter int D = 6
) (
  input  logic               clk,
  input  logic        [29:0] r2,
  input  logic signed [31:0] t,
  output logic signed [31:0] t_next
);

  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / D);
  localparam logic [30:0] DIV   = 31'(D);

  logic signed [63:0] prod_a;
  logic        [29:0] p_a;
  logic        [61:0] prod_b;
  logic        [29:0] p_b;
  logic        [29:0] q0_b;
  logic        [30:0] rem;
  logic        [29:0] q;

  // product is nonnegative and below 2^60
  always_comb prod_a = $signed({2'b00, r2}) * t;

  always_ff @(posedge clk) begin
    p_a <= prod_a[59:30];
  end

  // reciprocal estimate, low by at most one
  always_comb prod_b = p_a * RECIP;

  always_ff @(posedge clk) begin
    p_b  <= p_a;
    q0_b <= prod_b[61:32];
  end

  always_comb begin
    rem = {1'b0, p_b} - 31'(q0_b * DIV);
    q   = q0_b + ((rem >= DIV) ? 30'd1 : 30'd0);
  end

  always_ff @(posedge clk) begin
    t_next <= trsmm_pkg::Q30_ONE - $signed({2'b00, q});
  end

endmodule

// File: sv/trsmm_sincos.sv
// sine and cosine of three q3.12 angles: range reduction, quadrant split,
// horner series and quadrant mapping; depends on trsmm_pkg and trsmm_hstep
module trsmm_sincos (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [15:0] ang [3],
  output logic               out_valid,
  output logic signed [31:0] sin_o [3],
  output logic signed [31:0] cos_o [3]
);

  localparam int DL = 3 * trsmm_pkg::HSTEPS + 1;

  logic [trsmm_pkg::SC_LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[trsmm_pkg::SC_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[trsmm_pkg::SC_LAT-1];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [35:0] aw;
    logic signed [35:0] ared;
    logic signed [33:0] a1;
    logic signed [35:0] a1w;
    logic signed [2:0]  kq;
    logic signed [35:0] rw;
    logic signed [31:0] r0;
    logic signed [2:0]  k0;
    logic signed [31:0] r2w;
    logic signed [31:0] r_dl  [DL];
    logic signed [2:0]  k_dl  [DL];
    logic        [29:0] r2_dl [DL];
    logic signed [31:0] tsin  [trsmm_pkg::HSTEPS+1];
    logic signed [31:0] tcos  [trsmm_pkg::HSTEPS+1];
    logic signed [31:0] sr;
    logic signed [31:0] cr;
    logic signed [2:0]  kf;

    // widen to q30 and fold into [-pi, pi]
    always_comb begin
      aw = {{2{ang[g][15]}}, ang[g], 18'b0};
      if (aw > trsmm_pkg::Q30_PI) begin
        ared = aw - trsmm_pkg::Q30_TWO_PI;
      end else if (aw < -trsmm_pkg::Q30_PI) begin
        ared = aw + trsmm_pkg::Q30_TWO_PI;
      end else begin
        ared = aw;
      end
    end

    always_ff @(posedge clk) begin
      a1 <= ared[33:0];
    end

    // quadrant split, boundary takes the smaller quadrant
    always_comb begin
      a1w = 36'(a1);
      if (a1w > trsmm_pkg::Q30_3QTR_PI) begin
        kq = 3'sd2;
        rw = a1w - trsmm_pkg::Q30_PI;
      end else if (a1w > trsmm_pkg::Q30_QTR_PI) begin
        kq = 3'sd1;
        rw = a1w - trsmm_pkg::Q30_HALF_PI;
      end else if (a1w < -trsmm_pkg::Q30_3QTR_PI) begin
        kq = -3'sd2;
        rw = a1w + trsmm_pkg::Q30_PI;
      end else if (a1w < -trsmm_pkg::Q30_QTR_PI) begin
        kq = -3'sd1;
        rw = a1w + trsmm_pkg::Q30_HALF_PI;
      end else begin
        kq = 3'sd0;
        rw = a1w;
      end
    end

    always_ff @(posedge clk) begin
      r0 <= rw[31:0];
      k0 <= kq;
    end

    always_comb r2w = trsmm_pkg::mulq(r0, r0);

    always_ff @(posedge clk) begin
      r_dl[0]  <= r0;
      k_dl[0]  <= k0;
      r2_dl[0] <= r2w[29:0];
      for (int j = 1; j < DL; j++) begin
        r_dl[j]  <= r_dl[j-1];
        k_dl[j]  <= k_dl[j-1];
        r2_dl[j] <= r2_dl[j-1];
      end
    end

    assign tsin[0] = trsmm_pkg::Q30_ONE;
    assign tcos[0] = trsmm_pkg::Q30_ONE;

    for (genvar i = 0; i < trsmm_pkg::HSTEPS; i++) begin : g_step
      trsmm_hstep #(.D(trsmm_pkg::sin_div(i))) u_sin (
        .clk    (clk),
        .r2     (r2_dl[3*i]),
        .t      (tsin[i]),
        .t_next (tsin[i+1])
      );
      trsmm_hstep #(.D(trsmm_pkg::cos_div(i))) u_cos (
        .clk    (clk),
        .r2     (r2_dl[3*i]),
        .t      (tcos[i]),
        .t_next (tcos[i+1])
      );
    end

    always_ff @(posedge clk) begin
      sr <= trsmm_pkg::mulq(r_dl[DL-1], tsin[trsmm_pkg::HSTEPS]);
      cr <= tcos[trsmm_pkg::HSTEPS];
      kf <= k_dl[DL-1];
    end

    // quadrant mapping
    always_ff @(posedge clk) begin
      case (kf)
        3'sd1: begin
          sin_o[g] <= cr;
          cos_o[g] <= -sr;
        end
        -3'sd1: begin
          sin_o[g] <= -cr;
          cos_o[g] <= sr;
        end
        3'sd2, -3'sd2: begin
          sin_o[g] <= -sr;
          cos_o[g] <= -cr;
        end
        default: begin
          sin_o[g] <= sr;
          cos_o[g] <= cr;
        end
      endcase
    end
  end

endmodule

// File: sv/trsmm_rot.sv
// rotation product rx*ry*rz in q30, three register stages
// depends on trsmm_pkg
module trsmm_rot (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] s [3],
  input  logic signed [31:0] c [3],
  output logic               out_valid,
  output logic signed [31:0] elem [9]
);

  logic [trsmm_pkg::ROT_LAT-1:0] vld;

  logic signed [31:0] cycz, cysz, sxsy, cxsy, cxsz, cxcz, sxsz, sxcz, sxcy, cxcy;
  logic signed [31:0] cz1, sz1, sy1;
  logic signed [31:0] sxsycz, sxsysz, cxsycz, cxsysz;
  logic signed [31:0] cycz2, cysz2, cxsz2, cxcz2, sxsz2, sxcz2, sxcy2, cxcy2, sy2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[trsmm_pkg::ROT_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[trsmm_pkg::ROT_LAT-1];

  // pair products
  always_ff @(posedge clk) begin
    cycz <= trsmm_pkg::mulq(c[1], c[2]);
    cysz <= trsmm_pkg::mulq(c[1], s[2]);
    sxsy <= trsmm_pkg::mulq(s[0], s[1]);
    cxsy <= trsmm_pkg::mulq(c[0], s[1]);
    cxsz <= trsmm_pkg::mulq(c[0], s[2]);
    cxcz <= trsmm_pkg::mulq(c[0], c[2]);
    sxsz <= trsmm_pkg::mulq(s[0], s[2]);
    sxcz <= trsmm_pkg::mulq(s[0], c[2]);
    sxcy <= trsmm_pkg::mulq(s[0], c[1]);
    cxcy <= trsmm_pkg::mulq(c[0], c[1]);
    cz1  <= c[2];
    sz1  <= s[2];
    sy1  <= s[1];
  end

  // triple products, left to right
  always_ff @(posedge clk) begin
    sxsycz <= trsmm_pkg::mulq(sxsy, cz1);
    sxsysz <= trsmm_pkg::mulq(sxsy, sz1);
    cxsycz <= trsmm_pkg::mulq(cxsy, cz1);
    cxsysz <= trsmm_pkg::mulq(cxsy, sz1);
    cycz2  <= cycz;
    cysz2  <= cysz;
    cxsz2  <= cxsz;
    cxcz2  <= cxcz;
    sxsz2  <= sxsz;
    sxcz2  <= sxcz;
    sxcy2  <= sxcy;
    cxcy2  <= cxcy;
    sy2    <= sy1;
  end

  always_ff @(posedge clk) begin
    elem[0] <= cycz2;
    elem[1] <= -cysz2;
    elem[2] <= sy2;
    elem[3] <= sxsycz + cxsz2;
    elem[4] <= cxcz2 - sxsysz;
    elem[5] <= -sxcy2;
    elem[6] <= sxsz2 - cxsycz;
    elem[7] <= cxsysz + sxcz2;
    elem[8] <= cxcy2;
  end

endmodule

// File: sv/trsmm_rowout.sv
// row serializer: holds one matrix, scales each row by column, rounds,
// saturates and emits four rows; depends on trsmm_pkg
module trsmm_rowout (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [31:0] elem [9],
  input  trsmm_pkg::xf_t     xf,
  output logic               result_valid,
  output logic        [1:0]  row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_row
);

  logic signed [31:0] he [9];
  trsmm_pkg::xf_t     hx;
  logic        [1:0]  cnt;
  logic               active;

  logic signed [31:0] sel [3];
  logic signed [31:0] scl [3];
  logic signed [31:0] pos_sel;

  logic signed [63:0] prod [3];
  logic signed [31:0] m_pos;
  logic        [1:0]  m_row;
  logic               m_valid;

  logic signed [64:0] sum [3];
  logic signed [34:0] v   [3];
  logic signed [31:0] sat [3];

  always_ff @(posedge clk) begin
    if (in_valid) begin
      he <= elem;
      hx <= xf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      active <= 1'b0;
    end else if (in_valid) begin
      cnt    <= '0;
      active <= 1'b1;
    end else if (active) begin
      if (cnt == trsmm_pkg::LAST_ROW) begin
        active <= 1'b0;
      end else begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_comb begin
    scl[0] = hx.sx;
    scl[1] = hx.sy;
    scl[2] = hx.sz;
    case (cnt)
      2'd0: begin
        sel[0] = he[0]; sel[1] = he[1]; sel[2] = he[2];
        pos_sel = hx.px;
      end
      2'd1: begin
        sel[0] = he[3]; sel[1] = he[4]; sel[2] = he[5];
        pos_sel = hx.py;
      end
      2'd2: begin
        sel[0] = he[6]; sel[1] = he[7]; sel[2] = he[8];
        pos_sel = hx.pz;
      end
      default: begin
        sel[0] = '0; sel[1] = '0; sel[2] = '0;
        pos_sel = trsmm_pkg::Q16_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      prod[j] <= sel[j] * scl[j];
    end
    m_pos <= pos_sel;
    m_row <= cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= active;
    end
  end

  // round half up, then clamp
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sum[j] = 65'(prod[j]) + 65'sd536870912;
      v[j]   = sum[j][64:30];
      if (v[j] > 35'sd2147483647) begin
        sat[j] = 32'sh7fffffff;
      end else if (v[j] < -35'sd2147483648) begin
        sat[j] = 32'sh80000000;
      end else begin
        sat[j] = v[j][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    col0      <= sat[0];
    col1      <= sat[1];
    col2      <= sat[2];
    col3      <= m_pos;
    row_index <= m_row;
    last_row  <= (m_row == trsmm_pkg::LAST_ROW);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= m_valid;
    end
  end

endmodule

// File: sv/model_matrix_from_trs_unit.sv
// top level of the model matrix unit: input register, sine/cosine pipeline,
// rotation product and row serializer; depends on trsmm_pkg and all trsmm_* modules
//
// usage
//   input channel: drive the transform on pos_*, angle_*, scale_* and raise start;
//   the item is taken at the rising edge where start is high and busy is low
//   output channel: four rows per item, rows 0 to 3 in order, each held for
//   one cycle with result_valid high; last_row marks row 3
//   timing: row 0 passes the input register, the sine/cosine pipeline, the rotation
//   product and the row serializer; rows 1 to 3 follow back to back
//   throughput is set by the single row port that carries four rows per item;
//   busy stays high after an accept until the spacing counter reaches zero
//   the sine/cosine, rotation and scaling stages are fully pipelined, so up
//   to eight items are in flight at once
//   reset: synchronous, clears all valid bits and the busy counter; items
//   in flight are dropped
//   the receiver cannot stall: every row is presented exactly once
module model_matrix_from_trs_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic signed [15:0] angle_x,
  input  logic signed [15:0] angle_y,
  input  logic signed [15:0] angle_z,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  output logic               result_valid,
  output logic        [1:0]  row_index,
  output logic signed [31:0] col0,
  output logic signed [31:0] col1,
  output logic signed [31:0] col2,
  output logic signed [31:0] col3,
  output logic               last_row
);

  logic               accept;
  logic [1:0]         gap;

  // input register
  logic               v0;
  logic signed [15:0] ang [3];
  trsmm_pkg::xf_t     xf0;

  // pos/scale travel alongside the trig and rotation stages
  trsmm_pkg::xf_t     xf_dl [trsmm_pkg::XF_DLY];

  logic               sc_valid;
  logic signed [31:0] s [3];
  logic signed [31:0] c [3];
  logic               rot_valid;
  logic signed [31:0] elem [9];

  assign accept = start && !busy;
  assign busy   = (gap != 2'd0);

  // spacing counter: holds busy high after each accept until it counts down to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= '0;
    end else if (accept) begin
      gap <= 2'd3;
    end else if (gap != 2'd0) begin
      gap <= gap - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ang[0] <= angle_x;
      ang[1] <= angle_y;
      ang[2] <= angle_z;
      xf0    <= '{px: pos_x, py: pos_y, pz: pos_z, sx: scale_x, sy: scale_y, sz: scale_z};
    end
  end

  always_ff @(posedge clk) begin
    xf_dl[0] <= xf0;
    for (int j = 1; j < trsmm_pkg::XF_DLY; j++) begin
      xf_dl[j] <= xf_dl[j-1];
    end
  end

  trsmm_sincos u_sincos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v0),
    .ang       (ang),
    .out_valid (sc_valid),
    .sin_o     (s),
    .cos_o     (c)
  );

  trsmm_rot u_rot (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sc_valid),
    .s         (s),
    .c         (c),
    .out_valid (rot_valid),
    .elem      (elem)
  );

  trsmm_rowout u_rowout (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (rot_valid),
    .elem         (elem),
    .xf           (xf_dl[trsmm_pkg::XF_DLY-1]),
    .result_valid (result_valid),
    .row_index    (row_index),
    .col0         (col0),
    .col1         (col1),
    .col2         (col2),
    .col3         (col3),
    .last_row     (last_row)
  );

endmodule

// File: dv/testbench.sv
// testbench for model_matrix_from_trs_unit: drives transforms through the command port,
// predicts the four matrix rows per item and checks every row as it arrives
// depends on trsmm_pkg and the model matrix unit rtl
`timescale 1ns / 100ps

module testbench;

  localparam int  N_RANDOM    = 330;
  localparam int  DRAIN_WAIT  = 40;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic [31:0] Q16_UNIT = 32'h0001_0000;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0, c1, c2, c3;
    logic        last;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [15:0] angle_x = '0, angle_y = '0, angle_z = '0;
  logic signed [31:0] scale_x = '0, scale_y = '0, scale_z = '0;
  logic result_valid;
  logic [1:0] row_index;
  logic signed [31:0] col0, col1, col2, col3;
  logic last_row;

  row_t   pending_rows[$];
  int     mismatches = 0;
  int     idle_pct = 0;
  longint cycles = 0;

  model_matrix_from_trs_unit dut (
    .clk, .rst, .start, .busy,
    .pos_x, .pos_y, .pos_z, .angle_x, .angle_y, .angle_z,
    .scale_x, .scale_y, .scale_z,
    .result_valid, .row_index, .col0, .col1, .col2, .col3, .last_row
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: fixed point sine/cosine, rotation product, scaling per column
  // ---------------------------------------------------------------------------

  // q30 product with floor; >>> on a signed 64 bit value is a floor shift
  function automatic longint q30_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  // sine and cosine of a q3.12 angle, both in q30
  function automatic void angle_sincos(input logic signed [15:0] ang,
                                       output longint s, output longint c);
    longint a, r, r2, t, sr, cr;
    int quad;
    a = longint'(ang) * 262144;
    quad = 0;
    // fold into [-pi, pi]
    while (a > 64'sd3373259426) a -= 64'sd6746518852;
    while (a < -64'sd3373259426) a += 64'sd6746518852;
    // quadrant split, boundaries go to the smaller quadrant
    if (a > 64'sd2529944570) quad = 2;
    else if (a > 64'sd843314857) quad = 1;
    else if (a < -64'sd2529944570) quad = -2;
    else if (a < -64'sd843314857) quad = -1;
    r = a - longint'(quad) * 64'sd1686629713;
    r2 = q30_mul(r, r);
    // horner series, division truncates toward zero as sv does
    t = 64'sd1073741824 - q30_mul(r2, 64'sd1073741824) / 110;
    t = 64'sd1073741824 - q30_mul(r2, t) / 72;
    t = 64'sd1073741824 - q30_mul(r2, t) / 42;
    t = 64'sd1073741824 - q30_mul(r2, t) / 20;
    t = 64'sd1073741824 - q30_mul(r2, t) / 6;
    sr = q30_mul(r, t);
    t = 64'sd1073741824 - q30_mul(r2, 64'sd1073741824) / 90;
    t = 64'sd1073741824 - q30_mul(r2, t) / 56;
    t = 64'sd1073741824 - q30_mul(r2, t) / 30;
    t = 64'sd1073741824 - q30_mul(r2, t) / 12;
    cr = 64'sd1073741824 - q30_mul(r2, t) / 2;
    case (quad)
      1:       begin s = cr;  c = -sr; end
      -1:      begin s = -cr; c = sr;  end
      2, -2:   begin s = -sr; c = -cr; end
      default: begin s = sr;  c = cr;  end
    endcase
  endfunction

  // q30 element times q16.16 scale, round half up, clamp to 32 bits
  function automatic logic [31:0] scaled_elem(longint e, logic signed [31:0] scl);
    longint v;
    v = (e * longint'(scl) + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  task automatic predict_matrix(
      input logic signed [31:0] px, py, pz,
      input logic signed [15:0] ax, ay, az,
      input logic signed [31:0] kx, ky, kz);
    longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
    longint rot[3][3];
    logic signed [31:0] scl[3];
    logic [31:0] pos[3];
    row_t r;
    angle_sincos(ax, sx, cx);
    angle_sincos(ay, sy, cy);
    angle_sincos(az, sz, cz);
    sxsy = q30_mul(sx, sy);
    cxsy = q30_mul(cx, sy);
    rot[0][0] = q30_mul(cy, cz);
    rot[0][1] = -q30_mul(cy, sz);
    rot[0][2] = sy;
    rot[1][0] = q30_mul(sxsy, cz) + q30_mul(cx, sz);
    rot[1][1] = q30_mul(cx, cz) - q30_mul(sxsy, sz);
    rot[1][2] = -q30_mul(sx, cy);
    rot[2][0] = q30_mul(sx, sz) - q30_mul(cxsy, cz);
    rot[2][1] = q30_mul(cxsy, sz) + q30_mul(sx, cz);
    rot[2][2] = q30_mul(cx, cy);
    scl[0] = kx; scl[1] = ky; scl[2] = kz;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    for (int i = 0; i < 3; i++) begin
      r.row  = 2'(i);
      r.c0   = scaled_elem(rot[i][0], scl[0]);
      r.c1   = scaled_elem(rot[i][1], scl[1]);
      r.c2   = scaled_elem(rot[i][2], scl[2]);
      r.c3   = pos[i];
      r.last = 1'b0;
      pending_rows = {pending_rows, r};
    end
    // bottom row is always 0 0 0 1.0
    r.row = trsmm_pkg::LAST_ROW; r.c0 = '0; r.c1 = '0; r.c2 = '0; r.c3 = Q16_UNIT;
    r.last = 1'b1;
    pending_rows = {pending_rows, r};
  endtask

  // ---------------------------------------------------------------------------
  // row checker: every strobed row must match the oldest predicted row
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && result_valid) begin
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("row %0d arrived with nothing predicted", row_index);
      end else begin
        row_t e;
        e = pending_rows.pop_front();
        if (row_index !== e.row || col0 !== e.c0 || col1 !== e.c1 ||
            col2 !== e.c2 || col3 !== e.c3 || last_row !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected row %0d %h %h %h %h %b, got %0d %h %h %h %h %b",
                     e.row, e.c0, e.c1, e.c2, e.c3, e.last,
                     row_index, col0, col1, col2, col3, last_row);
        end
      end
    end
  end

  // timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // sends one transform; random idle cycles before it per the current idle rate
  // start stays high after the accept until the next idle cycle or drain
  task automatic send_transform(
      input logic signed [31:0] px, py, pz,
      input logic signed [15:0] ax, ay, az,
      input logic signed [31:0] kx, ky, kz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pos_x <= px; pos_y <= py; pos_z <= pz;
    angle_x <= ax; angle_y <= ay; angle_z <= az;
    scale_x <= kx; scale_y <= ky; scale_z <= kz;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    predict_matrix(px, py, pz, ax, ay, az, kx, ky, kz);
  endtask

  task automatic wait_all_rows();
    start <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
      2: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom_range(1) ? Q16_UNIT : -Q16_UNIT;
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(3))
      0, 1: return 16'($urandom());
      2: return 16'($signed($urandom_range(0, 2 * 12868)) - 12868);
      // near the quarter-pi boundaries
      default: return 16'($signed($urandom_range(0, 40)) - 20 +
                          ($urandom_range(1) ? 3217 : -3217));
    endcase
  endfunction

  // extremes of every field, quadrant boundaries and angle wrap
  task automatic test_directed();
    idle_pct = 0;
    send_transform('0, '0, '0, '0, '0, '0, Q16_UNIT, Q16_UNIT, Q16_UNIT);
    send_transform(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                   16'h7fff, 16'h8000, 16'h7fff,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_transform(32'h8000_0000, 32'h7fff_ffff, 32'h5555_aaaa,
                   16'h8000, 16'h7fff, 16'h8000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // angles near pi/4, 3pi/4, pi/2 and pi in q3.12
    send_transform(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                   16'sd3217, 16'sd9651, 16'sd6434,
                   32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
    send_transform(32'haaaa_5555, '0, '0, -16'sd3217, -16'sd9651, -16'sd6434,
                   -Q16_UNIT, Q16_UNIT, -Q16_UNIT);
    send_transform('0, '0, '0, 16'sd12868, -16'sd12868, 16'sd12867,
                   32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_transform('0, '0, '0, 16'sd3218, 16'sd9652, -16'sd3218,
                   32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
    send_transform('1, '1, '1, 16'sd25736, -16'sd25736, 16'sd1,
                   '0, '0, '0);
    send_transform(32'h1234_5678, 32'hedcb_a987, 32'h0f0f_f0f0,
                   16'h5555, 16'haaaa, 16'h0f0f,
                   32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff);
    wait_all_rows();
  endtask

  task automatic test_random_phase(input int count, input int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++)
      send_transform(rand_q16(), rand_q16(), rand_q16(),
                     rand_angle(), rand_angle(), rand_angle(),
                     rand_q16(), rand_q16(), rand_q16());
  endtask

  // sender holds off until every predicted row is out, then resumes
  task automatic test_pause_until_drained();
    test_random_phase(6, 0);
    wait_all_rows();
    test_random_phase(6, 0);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(N_RANDOM / 4, 0);
    test_random_phase(N_RANDOM / 4, 79);
    test_pause_until_drained();
    test_random_phase(N_RANDOM / 4, 7);
    test_random_phase(N_RANDOM / 4 - 12, 0);
    wait_all_rows();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && pending_rows.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
